### rtl/core/two_square_bigram_cipher_top_macros.svh
// Assertion macros for the two-square bigram cipher block.
// Used by two_square_bigram_cipher_top.sv; expects a clock named clk and reset rst.
`ifndef TWO_SQUARE_BIGRAM_CIPHER_TOP_MACROS_SVH
`define TWO_SQUARE_BIGRAM_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tsbc_pkg.sv
// Package for the two-square bigram cipher: request/result structs, lookup hit
// struct, cipher constants and the case-folding function. No dependencies.
package tsbc_pkg;

  localparam int unsigned LOC_W = 3;

  localparam logic [7:0] FOLD_ABOVE  = 8'd223;
  localparam logic [7:0] FOLD_DROP   = 8'd32;
  localparam logic [7:0] YO_LOWER    = 8'd184;
  localparam logic [7:0] YO_UPPER    = 8'd168;
  localparam logic [7:0] FILLER_BYTE = 8'd218;

  localparam logic [2:0] ADDR_DECRYPT = 3'd0;

  localparam logic FUNC_BIGRAM    = 1'b0;
  localparam logic FUNC_KEY_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESULT
  } tsbc_state_t;

  typedef struct packed {
    logic       func;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       square_select;
    logic [5:0] entry_index;
    logic [7:0] entry_value;
  } tsbc_in_t;

  typedef struct packed {
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic       passed_through;
  } tsbc_out_t;

  typedef struct packed {
    logic             found;
    logic [LOC_W-1:0] row;
    logic [LOC_W-1:0] col;
  } tsbc_hit_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    logic [7:0] f;
    if (b > FOLD_ABOVE) begin
      f = b - FOLD_DROP;
    end else if (b == YO_LOWER) begin
      f = YO_UPPER;
    end else begin
      f = b;
    end
    return f;
  endfunction

endpackage

### rtl/core/tsbc_lane.sv
// One key square cell: holds its byte and compares it with the search key.
// Depends on nothing outside this file.
module tsbc_lane (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [7:0] wr_data,
  input  logic [7:0] key,
  output logic       match
);

  logic [7:0] entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr_en) begin
      entry <= wr_data;
    end
  end

  assign match = (entry == key);

endmodule

### rtl/core/tsbc_merge.sv
// Merges the match flags of all cells of one square into the first hit,
// scanning row-major. Depends on tsbc_pkg.
module tsbc_merge #(
  parameter int unsigned SQUARE_SIDE = 6
) (
  input  logic [SQUARE_SIDE*SQUARE_SIDE-1:0] match,
  output tsbc_pkg::tsbc_hit_t                hit
);

  logic [SQUARE_SIDE-1:0]        row_hit;
  logic [tsbc_pkg::LOC_W-1:0]    row_col [SQUARE_SIDE];

  // First column within each row; rows are independent of each other.
  always_comb begin
    for (int r = 0; r < SQUARE_SIDE; r++) begin
      row_hit[r] = |match[r*SQUARE_SIDE +: SQUARE_SIDE];
      row_col[r] = '0;
      for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
        if (match[r*SQUARE_SIDE + c]) begin
          row_col[r] = tsbc_pkg::LOC_W'(c);
        end
      end
    end
  end

  always_comb begin
    hit.found = |row_hit;
    hit.row   = '0;
    hit.col   = '0;
    for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
      if (row_hit[r]) begin
        hit.row = tsbc_pkg::LOC_W'(r);
        hit.col = row_col[r];
      end
    end
  end

endmodule

### rtl/core/tsbc_sqmem.sv
// Read copy of one key square, used to fetch the output bytes.
// Valid bits make unwritten entries read as zero after reset. No dependencies.
module tsbc_sqmem #(
  parameter int unsigned CELLS = 36
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(CELLS)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(CELLS)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0]       mem [CELLS];
  logic [CELLS-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : 8'd0;
    end
  end

endmodule

### rtl/core/two_square_bigram_cipher_top.sv
// Top level of the two-square bigram cipher: lanes, merge, square memories, control.
// Depends on tsbc_pkg, tsbc_lane, tsbc_merge, tsbc_sqmem and the macros header.
//
//  channel   signals                               direction
//  in        in_valid, in_stall, in_data           request in
//  out       out_valid, out_stall, out_data        result out
//  config    psel, penable, pwrite, paddr, pwdata,  register access
//            prdata, pready
//
// A key write gives no result; the next request may follow at once.
// A bigram goes through capture, parallel lookup in all cells, output byte read
// from the square memories; then the result waits until it is taken.
// Requests are stalled from the capture of a bigram until its result is taken.
// Reset is synchronous; all key cells read as zero after it, with no clearing pass.
`include "two_square_bigram_cipher_top_macros.svh"

module two_square_bigram_cipher_top #(
  parameter int unsigned SQUARE_SIDE = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsbc_pkg::tsbc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsbc_pkg::tsbc_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CELLS = SQUARE_SIDE * SQUARE_SIDE;
  localparam int unsigned CW    = $clog2(CELLS);
  localparam int unsigned LW    = tsbc_pkg::LOC_W;
  localparam logic [LW-1:0] LAST_ROW = LW'(SQUARE_SIDE - 1);

  tsbc_pkg::tsbc_state_t state, state_next;

  logic       decrypt_mode;
  logic [7:0] bigram_first;
  logic [7:0] bigram_second;
  logic       passed;

  logic       in_accept, out_accept, key_write, bigram_accept;
  logic       lookup_en;
  logic       idx_ok;
  logic [7:0] second_eff;
  logic [7:0] key1, key2;

  logic [CELLS-1:0] match1, match2;
  tsbc_pkg::tsbc_hit_t hit1, hit2;

  logic [LW-1:0] row1, row2;
  logic [5:0]    addr1_full, addr2_full;
  logic [7:0]    rd1, rd2;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == tsbc_pkg::ADDR_DECRYPT)) begin
      decrypt_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr == tsbc_pkg::ADDR_DECRYPT) ? {31'd0, decrypt_mode} : 32'd0;

  // Handshakes
  assign in_accept     = in_valid && !in_stall;
  assign out_accept    = out_valid && !out_stall;
  assign key_write     = in_accept && (in_data.func == tsbc_pkg::FUNC_KEY_WRITE);
  assign bigram_accept = in_accept && (in_data.func == tsbc_pkg::FUNC_BIGRAM);
  assign idx_ok        = (7'(in_data.entry_index) < 7'(CELLS));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tsbc_pkg::ST_IDLE:   if (bigram_accept) state_next = tsbc_pkg::ST_LOOKUP;
      tsbc_pkg::ST_LOOKUP: state_next = tsbc_pkg::ST_RESULT;
      tsbc_pkg::ST_RESULT: if (out_accept) state_next = tsbc_pkg::ST_IDLE;
      default:             state_next = tsbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    lookup_en = 1'b0;
    unique case (state)
      tsbc_pkg::ST_IDLE:   in_stall  = 1'b0;
      tsbc_pkg::ST_LOOKUP: lookup_en = 1'b1;
      tsbc_pkg::ST_RESULT: out_valid = 1'b1;
      default:             in_stall  = 1'b1;
    endcase
  end

  // Capture; when encrypting, a doubled letter has its second byte replaced by the filler.
  assign second_eff = (!decrypt_mode && (in_data.first_byte == in_data.second_byte))
                      ? tsbc_pkg::FILLER_BYTE : in_data.second_byte;

  always_ff @(posedge clk) begin
    if (bigram_accept) begin
      bigram_first  <= in_data.first_byte;
      bigram_second <= second_eff;
    end
  end

  assign key1 = tsbc_pkg::fold_upper(bigram_first);
  assign key2 = tsbc_pkg::fold_upper(bigram_second);

  // One lane per cell of each square
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    tsbc_lane u_lane1 (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (key_write && !in_data.square_select && (in_data.entry_index == 6'(k))),
      .wr_data (in_data.entry_value),
      .key     (key1),
      .match   (match1[k])
    );
    tsbc_lane u_lane2 (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (key_write && in_data.square_select && (in_data.entry_index == 6'(k))),
      .wr_data (in_data.entry_value),
      .key     (key2),
      .match   (match2[k])
    );
  end

  tsbc_merge #(.SQUARE_SIDE(SQUARE_SIDE)) u_merge1 (.match(match1), .hit(hit1));
  tsbc_merge #(.SQUARE_SIDE(SQUARE_SIDE)) u_merge2 (.match(match2), .hit(hit2));

  // Same column with differing bytes: both rows move one place, wrapping.
  always_comb begin
    row1 = hit1.row;
    row2 = hit2.row;
    if ((hit1.col == hit2.col) && (bigram_first != bigram_second)) begin
      if (!decrypt_mode) begin
        row1 = (hit1.row == LAST_ROW) ? '0 : hit1.row + 1'b1;
        row2 = (hit2.row == LAST_ROW) ? '0 : hit2.row + 1'b1;
      end else begin
        row1 = (hit1.row == '0) ? LAST_ROW : hit1.row - 1'b1;
        row2 = (hit2.row == '0) ? LAST_ROW : hit2.row - 1'b1;
      end
    end
  end

  assign addr1_full = 6'(row1) * 6'(SQUARE_SIDE) + 6'(hit2.col);
  assign addr2_full = 6'(row2) * 6'(SQUARE_SIDE) + 6'(hit1.col);

  tsbc_sqmem #(.CELLS(CELLS)) u_mem1 (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (key_write && !in_data.square_select && idx_ok),
    .wr_addr (in_data.entry_index[CW-1:0]),
    .wr_data (in_data.entry_value),
    .rd_en   (lookup_en),
    .rd_addr (addr1_full[CW-1:0]),
    .rd_data (rd1)
  );

  tsbc_sqmem #(.CELLS(CELLS)) u_mem2 (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (key_write && in_data.square_select && idx_ok),
    .wr_addr (in_data.entry_index[CW-1:0]),
    .wr_data (in_data.entry_value),
    .rd_en   (lookup_en),
    .rd_addr (addr2_full[CW-1:0]),
    .rd_data (rd2)
  );

  always_ff @(posedge clk) begin
    if (lookup_en) begin
      passed <= !(hit1.found && hit2.found);
    end
  end

  assign out_data.out_first      = passed ? bigram_first  : rd1;
  assign out_data.out_second     = passed ? bigram_second : rd2;
  assign out_data.passed_through = passed;

  // Assertions
  `TSBC_ASSERT_NOW(a_result_blocks_requests, out_valid, in_stall,
                   "request taken while a result is pending")
  `TSBC_ASSERT_NEXT(a_bigram_starts_lookup, bigram_accept, lookup_en && !out_valid,
                    "bigram did not enter the lookup cycle")
  `TSBC_ASSERT_NEXT(a_lookup_gives_result, lookup_en, out_valid,
                    "lookup was not followed by a result")
  `TSBC_ASSERT_NEXT(a_key_write_no_result, key_write && !out_valid, !out_valid,
                    "key write produced a result")

endmodule

### tb/bigram_cipher_checker.sv
// Result checker for the two-square bigram cipher: watches the request, result and
// register channels, predicts every bigram result and compares it field by field.
// Depends on tsbc_pkg for the channel structs and the cipher constants.
module bigram_cipher_checker #(
  parameter int SIDE = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tsbc_pkg::tsbc_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tsbc_pkg::tsbc_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output int                  pending,
  output int                  fail_count
);

  localparam int CELLS = SIDE * SIDE;
  localparam int REPORT_LIMIT = 10;

  logic [7:0]          key_first [CELLS];
  logic [7:0]          key_second [CELLS];
  logic                decrypt_mode;
  tsbc_pkg::tsbc_out_t expected_bigrams [$];

  function automatic logic [7:0] upper_form(input logic [7:0] sym);
    if (sym > tsbc_pkg::FOLD_ABOVE) return sym - tsbc_pkg::FOLD_DROP;
    if (sym == tsbc_pkg::YO_LOWER) return tsbc_pkg::YO_UPPER;
    return sym;
  endfunction

  // Row-major search; the first matching cell wins, -1 when the symbol is absent.
  function automatic int find_cell(input bit in_second, input logic [7:0] sym);
    logic [7:0] wanted;
    wanted = upper_form(sym);
    for (int i = 0; i < CELLS; i++) begin
      if ((in_second ? key_second[i] : key_first[i]) == wanted) return i;
    end
    return -1;
  endfunction

  function automatic tsbc_pkg::tsbc_out_t cipher_bigram(input logic [7:0] a,
                                                        input logic [7:0] b_raw);
    tsbc_pkg::tsbc_out_t res;
    logic [7:0]          b;
    int                  p1, p2, r1, c1, r2, c2;
    b = (!decrypt_mode && a == b_raw) ? tsbc_pkg::FILLER_BYTE : b_raw;
    p1 = find_cell(1'b0, a);
    p2 = find_cell(1'b1, b);
    if (p1 < 0 || p2 < 0) begin
      res.out_first = a;
      res.out_second = b;
      res.passed_through = 1'b1;
      return res;
    end
    r1 = p1 / SIDE;
    c1 = p1 % SIDE;
    r2 = p2 / SIDE;
    c2 = p2 % SIDE;
    // Shared column: both rows step down when encrypting and up when decrypting.
    if (c1 == c2 && a != b) begin
      if (decrypt_mode) begin
        r1 = (r1 == 0) ? SIDE - 1 : r1 - 1;
        r2 = (r2 == 0) ? SIDE - 1 : r2 - 1;
      end else begin
        r1 = (r1 == SIDE - 1) ? 0 : r1 + 1;
        r2 = (r2 == SIDE - 1) ? 0 : r2 + 1;
      end
    end
    res.out_first = key_first[r1 * SIDE + c2];
    res.out_second = key_second[r2 * SIDE + c1];
    res.passed_through = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    tsbc_pkg::tsbc_out_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        key_first[i] = 8'd0;
        key_second[i] = 8'd0;
      end
      decrypt_mode = 1'b0;
      expected_bigrams.delete();
    end else begin
      // The block registers each bigram before its lookup and its result, so a result taken at this edge
      // always belongs to a request accepted at an earlier one.
      if (out_valid && !out_stall) begin
        if (expected_bigrams.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("bad result: none expected, got %h %h %b",
                     out_data.out_first, out_data.out_second, out_data.passed_through);
          end
          fail_count++;
        end else begin
          want = expected_bigrams.pop_front();
          if (want.out_first !== out_data.out_first ||
              want.out_second !== out_data.out_second ||
              want.passed_through !== out_data.passed_through) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("bad result: expected %h %h %b, got %h %h %b",
                       want.out_first, want.out_second, want.passed_through,
                       out_data.out_first, out_data.out_second, out_data.passed_through);
            end
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == tsbc_pkg::ADDR_DECRYPT) begin
        decrypt_mode = pwdata[0];
      end
      if (in_valid && !in_stall) begin
        if (in_data.func == tsbc_pkg::FUNC_KEY_WRITE) begin
          if (in_data.entry_index < CELLS) begin
            if (in_data.square_select) begin
              key_second[in_data.entry_index] = in_data.entry_value;
            end else begin
              key_first[in_data.entry_index] = in_data.entry_value;
            end
          end
        end else begin
          expected_bigrams.push_back(cipher_bigram(in_data.first_byte, in_data.second_byte));
        end
      end
    end
    pending = expected_bigrams.size();
  end

endmodule

### tb/tb_top.sv
// Testbench top for the two-square bigram cipher: clock, reset, request and
// register stimulus, result-side stalls and the verdict.
// Depends on tsbc_pkg, two_square_bigram_cipher_top and bigram_cipher_checker.
module tb_top;

  localparam int SIDE = 6;
  localparam int CELLS = SIDE * SIDE;
  localparam int LONG_HOLD = 150;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  tsbc_pkg::tsbc_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  tsbc_pkg::tsbc_out_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  pending;
  int                  fail_count;

  // Copies of the key squares as written, used only to aim bigrams at stored symbols.
  logic [7:0]  shadow_first [CELLS];
  logic [7:0]  shadow_second [CELLS];
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;

  two_square_bigram_cipher_top #(.SQUARE_SIDE(SIDE)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bigram_cipher_checker #(.SIDE(SIDE)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic tsbc_pkg::tsbc_in_t key_item(input logic sel, input int idx,
                                                  input logic [7:0] val);
    tsbc_pkg::tsbc_in_t req;
    req = tsbc_pkg::tsbc_in_t'($urandom);
    req.func = tsbc_pkg::FUNC_KEY_WRITE;
    req.square_select = sel;
    req.entry_index = 6'(idx);
    req.entry_value = val;
    return req;
  endfunction

  function automatic tsbc_pkg::tsbc_in_t bigram_item(input logic [7:0] a,
                                                     input logic [7:0] b);
    tsbc_pkg::tsbc_in_t req;
    req = tsbc_pkg::tsbc_in_t'($urandom);
    req.func = tsbc_pkg::FUNC_BIGRAM;
    req.first_byte = a;
    req.second_byte = b;
    return req;
  endfunction

  // Mostly upper-case letters, some Yo, the rest any byte at all.
  function automatic logic [7:0] any_symbol();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom);
      3:       return tsbc_pkg::YO_UPPER;
      default: return 8'($urandom_range(tsbc_pkg::FOLD_ABOVE - tsbc_pkg::FOLD_DROP + 1,
                                        tsbc_pkg::FOLD_ABOVE));
    endcase
  endfunction

  function automatic logic [7:0] lower_case(input logic [7:0] v);
    if (v > tsbc_pkg::FOLD_ABOVE - tsbc_pkg::FOLD_DROP && v <= tsbc_pkg::FOLD_ABOVE &&
        $urandom_range(0, 1)) begin
      return v + tsbc_pkg::FOLD_DROP;
    end
    if (v == tsbc_pkg::YO_UPPER && $urandom_range(0, 1)) return tsbc_pkg::YO_LOWER;
    return v;
  endfunction

  task automatic offer(input tsbc_pkg::tsbc_in_t req);
    bit taken;
    if (req.func == tsbc_pkg::FUNC_KEY_WRITE && req.entry_index < CELLS) begin
      if (req.square_select) begin
        shadow_second[req.entry_index] = req.entry_value;
      end else begin
        shadow_first[req.entry_index] = req.entry_value;
      end
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    // A key write leaves no result behind, so give it time to land.
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mode(input logic decrypt);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tsbc_pkg::ADDR_DECRYPT;
    pwdata <= 32'(decrypt);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // The planned key puts letters in order in the first square and in reverse in
  // the second, with Yo, a shared Latin letter, a duplicate and a zero cell at the end.
  task automatic load_squares(input bit planned);
    logic [7:0] v1, v2;
    for (int i = 0; i < CELLS; i++) begin
      if (!planned) begin
        v1 = any_symbol();
        v2 = any_symbol();
      end else begin
        case (i)
          32:      begin v1 = tsbc_pkg::YO_UPPER; v2 = tsbc_pkg::YO_UPPER; end
          33:      begin v1 = 8'h41;    v2 = 8'h41;    end
          34:      begin v1 = 8'hC0;    v2 = 8'h42;    end
          35:      begin v1 = 8'h00;    v2 = 8'h00;    end
          default: begin v1 = 8'(8'hC0 + i); v2 = 8'(tsbc_pkg::FOLD_ABOVE - i); end
        endcase
      end
      offer(key_item(1'b0, i, v1));
      offer(key_item(1'b1, i, v2));
    end
  endtask

  task automatic random_items(input int count);
    tsbc_pkg::tsbc_in_t req;
    int                 i1, i2;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        req = key_item(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(CELLS, 63)
                                                   : $urandom_range(0, CELLS - 1),
                       any_symbol());
      end else begin
        req = bigram_item(8'($urandom), 8'($urandom));
        // Most bigrams use stored symbols so that the lookup actually hits.
        if ($urandom_range(0, 9) < 7) begin
          i1 = $urandom_range(0, CELLS - 1);
          if ($urandom_range(0, 3) == 0) begin
            i2 = $urandom_range(0, SIDE - 1) * SIDE + i1 % SIDE;
          end else begin
            i2 = $urandom_range(0, CELLS - 1);
          end
          req.first_byte = lower_case(shadow_first[i1]);
          req.second_byte = lower_case(shadow_second[i2]);
        end
        if ($urandom_range(0, 7) == 0) req.second_byte = req.first_byte;
      end
      offer(req);
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int i = 0; i < CELLS; i++) begin
      shadow_first[i] = 8'd0;
      shadow_second[i] = 8'd0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fresh squares hold only zeros, so only byte zero can be found.
    set_mode(1'b0);
    offer(bigram_item(8'h00, 8'h00));
    offer(bigram_item(8'h00, 8'hA5));
    load_squares(1'b1);
    offer(key_item(1'b1, CELLS, 8'h00));
    offer(key_item(1'b0, 63, 8'hC1));
    offer(bigram_item(8'hE0, 8'hFF));
    offer(bigram_item(8'hB8, 8'hB8));
    offer(bigram_item(8'hDE, 8'hC1));
    offer(bigram_item(8'h41, 8'h41));
    offer(bigram_item(8'h10, 8'hC0));
    offer(bigram_item(8'hC0, 8'h10));
    offer(bigram_item(8'hFF, 8'h00));
    offer(bigram_item(8'h00, 8'hFF));
    offer(bigram_item(8'hC1, 8'hC2));

    set_mode(1'b1);
    offer(bigram_item(8'hE0, 8'hFF));
    offer(bigram_item(8'hDE, 8'hC1));
    offer(bigram_item(8'h41, 8'h41));
    offer(bigram_item(8'h00, 8'h00));
    offer(bigram_item(8'hB8, 8'hA8));
    offer(bigram_item(8'hD5, 8'hD5));

    set_mode(1'b0);
    random_items(100);
    set_mode(1'b1);
    load_squares(1'b0);
    random_items(100);
    set_mode(1'b0);
    random_items(25);
    hold_request = 1'b1;
    random_items(80);
    set_mode(1'b1);
    load_squares(1'b0);
    random_items(40);
    calm = 1'b1;
    random_items(70);

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
